[rtl/fbap_pkg.sv]
// fbap_pkg: shared constants, types and fixed divider constants for the fader block averager
// no dependencies
`timescale 1ns / 1ps

package fbap_pkg;

    // block configuration
    localparam int CHANNELS     = 4;
    localparam int BLOCK_LENGTH = 16;
    localparam int MAX_CH       = 4;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 7;

    // accumulator holds BLOCK_LENGTH * 4095
    localparam int SUM_W = SAMPLE_W + $clog2(BLOCK_LENGTH);
    localparam int CNT_W = $clog2(BLOCK_LENGTH + 1);

    // mean = sum / BLOCK_LENGTH as multiply by rounded-up reciprocal, exact for sum < 2^SUM_W
    localparam int MEAN_SHIFT   = SUM_W + $clog2(BLOCK_LENGTH);
    localparam int MEAN_RECIP_W = SUM_W + 1;
    localparam int MEAN_PROD_W  = SUM_W + MEAN_RECIP_W;
    localparam longint unsigned MEAN_RECIP_L =
        ((64'd1 << MEAN_SHIFT) + 64'(BLOCK_LENGTH) - 64'd1) / 64'(BLOCK_LENGTH);
    localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = MEAN_RECIP_W'(MEAN_RECIP_L);

    // level = mean / 41, same scheme, exact for mean < 2^SAMPLE_W
    localparam int LEVEL_DIVISOR = 41;
    localparam int LEVEL_SHIFT   = SAMPLE_W + $clog2(LEVEL_DIVISOR);
    localparam int LEVEL_RECIP_W = SAMPLE_W + 1;
    localparam int LEVEL_PROD_W  = SAMPLE_W + LEVEL_RECIP_W;
    localparam longint unsigned LEVEL_RECIP_L =
        ((64'd1 << LEVEL_SHIFT) + 64'(LEVEL_DIVISOR) - 64'd1) / 64'(LEVEL_DIVISOR);
    localparam logic [LEVEL_RECIP_W-1:0] LEVEL_RECIP = LEVEL_RECIP_W'(LEVEL_RECIP_L);

    // queue between accumulator and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SUM_W-1:0]    t_sum;
    typedef t_sum [CHANNELS-1:0] t_sum_vec;

    // one finished block as it travels from the accumulator to the back end
    typedef struct packed {
        logic     valid;
        t_sum_vec sums;
    } t_block_push;

endpackage

[rtl/fbap_in_if.sv]
// fbap_in_if: frame channel, four fader samples per word
// depends on fbap_pkg
`timescale 1ns / 1ps

interface fbap_in_if;
    logic                         valid;
    logic                         ready;
    logic [fbap_pkg::SAMPLE_W-1:0] sample_0;
    logic [fbap_pkg::SAMPLE_W-1:0] sample_1;
    logic [fbap_pkg::SAMPLE_W-1:0] sample_2;
    logic [fbap_pkg::SAMPLE_W-1:0] sample_3;

    modport source (output valid, output sample_0, output sample_1, output sample_2,
                    output sample_3, input ready);
    modport sink   (input valid, input sample_0, input sample_1, input sample_2,
                    input sample_3, output ready);
endinterface

[rtl/fbap_out_if.sv]
// fbap_out_if: block result channel, levels, means and change mask
// depends on fbap_pkg
`timescale 1ns / 1ps

interface fbap_out_if;
    logic                          valid;
    logic                          ready;
    logic [fbap_pkg::LEVEL_W-1:0]  level_0;
    logic [fbap_pkg::LEVEL_W-1:0]  level_1;
    logic [fbap_pkg::LEVEL_W-1:0]  level_2;
    logic [fbap_pkg::LEVEL_W-1:0]  level_3;
    logic [fbap_pkg::SAMPLE_W-1:0] mean_0;
    logic [fbap_pkg::SAMPLE_W-1:0] mean_1;
    logic [fbap_pkg::SAMPLE_W-1:0] mean_2;
    logic [fbap_pkg::SAMPLE_W-1:0] mean_3;
    logic [fbap_pkg::MAX_CH-1:0]   changed_mask;

    modport source  (output valid, output level_0, output level_1, output level_2,
                     output level_3, output mean_0, output mean_1, output mean_2,
                     output mean_3, output changed_mask, input ready);
    modport sink    (input valid, input level_0, input level_1, input level_2,
                     input level_3, input mean_0, input mean_1, input mean_2,
                     input mean_3, input changed_mask, output ready);
    modport monitor (input valid, input level_0, input level_1, input level_2,
                     input level_3, input mean_0, input mean_1, input mean_2,
                     input mean_3, input changed_mask, input ready);
endinterface

[rtl/fbap_front.sv]
// fbap_front: per-channel accumulators and frame counter, hands finished blocks to the queue
// depends on fbap_pkg, fbap_in_if
`timescale 1ns / 1ps

module fbap_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fbap_in_if.sink               i_frame,
    output fbap_pkg::t_block_push o_push,
    input  logic                  i_push_ready
);

    logic [fbap_pkg::CNT_W-1:0] r_count, n_count;
    fbap_pkg::t_sum_vec         r_sums, n_sums;
    fbap_pkg::t_sum_vec         w_acc;
    logic [fbap_pkg::MAX_CH-1:0][fbap_pkg::SAMPLE_W-1:0] w_samples;
    logic                       w_last;
    logic                       w_accept;

    assign w_samples = {i_frame.sample_3, i_frame.sample_2, i_frame.sample_1, i_frame.sample_0};
    assign w_last    = (r_count == fbap_pkg::CNT_W'(fbap_pkg::BLOCK_LENGTH - 1));

    // only the closing frame of a block needs room in the queue
    assign i_frame.ready = !w_last || i_push_ready;
    assign w_accept      = i_frame.valid && i_frame.ready;

    always_comb begin
        for (int c = 0; c < fbap_pkg::CHANNELS; c++) begin
            w_acc[c] = r_sums[c] + fbap_pkg::SUM_W'(w_samples[c]);
        end
    end

    assign o_push.valid = i_frame.valid && w_last;
    assign o_push.sums  = w_acc;

    always_comb begin
        n_count = r_count;
        n_sums  = r_sums;
        if (w_accept) begin
            if (w_last) begin
                n_count = '0;
                n_sums  = '0;
            end else begin
                n_count = r_count + fbap_pkg::CNT_W'(1);
                n_sums  = w_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sums  <= '0;
        end else begin
            r_count <= n_count;
            r_sums  <= n_sums;
        end
    end

endmodule

[rtl/fbap_queue.sv]
// fbap_queue: short flop queue of finished block sums between front and back
// depends on fbap_pkg
`timescale 1ns / 1ps

module fbap_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fbap_pkg::t_block_push i_push,
    output logic                  o_push_ready,
    output fbap_pkg::t_block_push o_pop,
    input  logic                  i_pop_ready
);

    fbap_pkg::t_sum_vec            r_mem [fbap_pkg::QUEUE_DEPTH];
    logic [fbap_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [fbap_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [fbap_pkg::QUEUE_CW-1:0] r_fill, n_fill;
    logic                          w_push;
    logic                          w_pop;

    assign o_push_ready = (r_fill != fbap_pkg::QUEUE_CW'(fbap_pkg::QUEUE_DEPTH));
    assign o_pop.valid  = (r_fill != '0);
    assign o_pop.sums   = r_mem[r_rd_ptr];

    assign w_push = i_push.valid && o_push_ready;
    assign w_pop  = o_pop.valid && i_pop_ready;

    function automatic logic [fbap_pkg::QUEUE_AW-1:0] ptr_inc(
        input logic [fbap_pkg::QUEUE_AW-1:0] ptr);
        if (ptr == fbap_pkg::QUEUE_AW'(fbap_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + fbap_pkg::QUEUE_AW'(1);
    endfunction

    always_comb begin
        n_wr_ptr = w_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = w_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_fill   = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + fbap_pkg::QUEUE_CW'(1);
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - fbap_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.sums;
        end
    end

endmodule

[rtl/fbap_back.sv]
// fbap_back: two-stage mean / level pipeline with change detect and output register
// depends on fbap_pkg, fbap_out_if
`timescale 1ns / 1ps

module fbap_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fbap_pkg::t_block_push i_pop,
    output logic                  o_pop_ready,
    fbap_out_if.source            o_block
);

    typedef logic [fbap_pkg::SAMPLE_W-1:0] t_mean;
    typedef logic [fbap_pkg::LEVEL_W-1:0]  t_level;

    // stage a: means
    logic                           r_a_valid;
    t_mean [fbap_pkg::CHANNELS-1:0] r_a_mean, n_a_mean;
    // stage b: output register
    logic                           r_b_valid;
    t_mean  [fbap_pkg::CHANNELS-1:0] r_b_mean;
    t_level [fbap_pkg::CHANNELS-1:0] r_b_level, n_b_level;
    logic   [fbap_pkg::MAX_CH-1:0]   r_b_mask, n_b_mask;
    // levels of the last block that left stage a
    t_level [fbap_pkg::CHANNELS-1:0] r_prev;

    logic w_b_load;
    logic w_a_load;

    assign w_b_load    = r_a_valid && (!r_b_valid || o_block.ready);
    assign o_pop_ready = !r_a_valid || w_b_load;
    assign w_a_load    = i_pop.valid && o_pop_ready;

    always_comb begin
        logic [fbap_pkg::MEAN_PROD_W-1:0] prod;
        for (int c = 0; c < fbap_pkg::CHANNELS; c++) begin
            prod = fbap_pkg::MEAN_PROD_W'(i_pop.sums[c])
                 * fbap_pkg::MEAN_PROD_W'(fbap_pkg::MEAN_RECIP);
            n_a_mean[c] = prod[fbap_pkg::MEAN_SHIFT +: fbap_pkg::SAMPLE_W];
        end
    end

    always_comb begin
        logic [fbap_pkg::LEVEL_PROD_W-1:0] prod;
        n_b_mask = '0;
        for (int c = 0; c < fbap_pkg::CHANNELS; c++) begin
            prod = fbap_pkg::LEVEL_PROD_W'(r_a_mean[c])
                 * fbap_pkg::LEVEL_PROD_W'(fbap_pkg::LEVEL_RECIP);
            n_b_level[c] = prod[fbap_pkg::LEVEL_SHIFT +: fbap_pkg::LEVEL_W];
            n_b_mask[c]  = (n_b_level[c] != r_prev[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_prev    <= '0;
        end else begin
            if (o_pop_ready) begin
                r_a_valid <= i_pop.valid;
            end
            if (w_b_load) begin
                r_b_valid <= 1'b1;
                r_prev    <= n_b_level;
            end else if (o_block.ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_load) begin
            r_a_mean <= n_a_mean;
        end
        if (w_b_load) begin
            r_b_mean  <= r_a_mean;
            r_b_level <= n_b_level;
            r_b_mask  <= n_b_mask;
        end
    end

    // unused channels read as zero
    always_comb begin
        t_mean  [fbap_pkg::MAX_CH-1:0] mean_all;
        t_level [fbap_pkg::MAX_CH-1:0] level_all;
        mean_all  = '0;
        level_all = '0;
        for (int c = 0; c < fbap_pkg::CHANNELS; c++) begin
            mean_all[c]  = r_b_mean[c];
            level_all[c] = r_b_level[c];
        end
        o_block.mean_0  = mean_all[0];
        o_block.mean_1  = mean_all[1];
        o_block.mean_2  = mean_all[2];
        o_block.mean_3  = mean_all[3];
        o_block.level_0 = level_all[0];
        o_block.level_1 = level_all[1];
        o_block.level_2 = level_all[2];
        o_block.level_3 = level_all[3];
    end

    assign o_block.valid        = r_b_valid;
    assign o_block.changed_mask = r_b_mask;

endmodule

[rtl/fader_block_average_percent_unit.sv]
// fader_block_average_percent_unit: top level of the fader boxcar averager
// depends on fbap_pkg, fbap_in_if, fbap_out_if, fbap_front, fbap_queue, fbap_back
`timescale 1ns / 1ps

// channel   dir  word                                    handshake
// i_frame   in   sample_0..sample_3, 12 bit unsigned     valid / ready
// o_block   out  level_0..3, mean_0..3, changed_mask     valid / ready
//
// one frame word accepted every cycle while the queue has room for closing frames; the accumulator adder is the only
// work on the frame path, so there is no other limit while the output drains
// a block result goes from its closing frame through the queue, the mean multiply, then the level
// multiply and compare into the output register
// synchronous active-low reset clears accumulators, frame count, previous levels,
// queue and pipeline valids; no clearing pass
// a stalled output backs up the pipeline, then the two-entry queue; only the closing
// frame of a block waits for queue room, other frames keep flowing

module fader_block_average_percent_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fbap_in_if.sink    i_frame,
    fbap_out_if.source o_block
);

    // finished block sums from the accumulator into the queue
    fbap_pkg::t_block_push w_push;
    logic                  w_push_ready;

    // head of the queue into the mean / level pipeline
    fbap_pkg::t_block_push w_pop;
    logic                  w_pop_ready;

    // front: accumulate four channels, count frames, close the block
    fbap_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (i_frame),
        .o_push       (w_push),
        .i_push_ready (w_push_ready)
    );

    // decoupling queue so a stalled consumer does not stop accumulation until the queue is full
    fbap_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_pop        (w_pop),
        .i_pop_ready  (w_pop_ready)
    );

    // back: mean, level, change mask, output register
    fbap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (w_pop),
        .o_pop_ready (w_pop_ready),
        .o_block     (o_block)
    );

endmodule

[rtl/fbap_checker.sv]
// fbap_checker: port-level assertions for the fader block averager, bound to the top level
// depends on fbap_pkg, fbap_out_if, fader_block_average_percent_unit
`timescale 1ns / 1ps

module fbap_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [fbap_pkg::LEVEL_W-1:0]  i_level_0,
    input logic [fbap_pkg::LEVEL_W-1:0]  i_level_1,
    input logic [fbap_pkg::LEVEL_W-1:0]  i_level_2,
    input logic [fbap_pkg::LEVEL_W-1:0]  i_level_3,
    input logic [fbap_pkg::SAMPLE_W-1:0] i_mean_0,
    input logic [fbap_pkg::SAMPLE_W-1:0] i_mean_1,
    input logic [fbap_pkg::SAMPLE_W-1:0] i_mean_2,
    input logic [fbap_pkg::SAMPLE_W-1:0] i_mean_3,
    input logic [fbap_pkg::MAX_CH-1:0]   i_changed_mask
);

    // level must equal mean / 41 truncated
    function automatic logic level_ok(input logic [fbap_pkg::LEVEL_W-1:0] lvl,
                                      input logic [fbap_pkg::SAMPLE_W-1:0] mean);
        logic [fbap_pkg::SAMPLE_W+1:0] lo;
        logic [fbap_pkg::SAMPLE_W+1:0] m;
        lo = (fbap_pkg::SAMPLE_W+2)'(lvl) * (fbap_pkg::SAMPLE_W+2)'(fbap_pkg::LEVEL_DIVISOR);
        m  = (fbap_pkg::SAMPLE_W+2)'(mean);
        return (lo <= m) && (m < lo + (fbap_pkg::SAMPLE_W+2)'(fbap_pkg::LEVEL_DIVISOR));
    endfunction

    a_reset_no_word: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result word valid right after reset");

    a_level_matches_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (level_ok(i_level_0, i_mean_0)
                  && level_ok(i_level_1, i_mean_1)
                  && level_ok(i_level_2, i_mean_2)
                  && level_ok(i_level_3, i_mean_3)))
        else $error("level does not match mean / 41");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result word dropped while stalled");

    a_word_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_changed_mask)
            && $stable(i_mean_0) && $stable(i_mean_1)
            && $stable(i_mean_2) && $stable(i_mean_3))
        else $error("result word changed while stalled");

endmodule

bind fader_block_average_percent_unit fbap_checker u_fbap_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_block.valid),
    .i_ready        (o_block.ready),
    .i_level_0      (o_block.level_0),
    .i_level_1      (o_block.level_1),
    .i_level_2      (o_block.level_2),
    .i_level_3      (o_block.level_3),
    .i_mean_0       (o_block.mean_0),
    .i_mean_1       (o_block.mean_1),
    .i_mean_2       (o_block.mean_2),
    .i_mean_3       (o_block.mean_3),
    .i_changed_mask (o_block.changed_mask)
);

[tb/sv/tb_fader_block_average_percent_unit.sv]
// tb_fader_block_average_percent_unit: self-checking bench for the fader boxcar averager
// drives frame words, predicts block means, levels and change masks, compares each result
// depends on fbap_pkg, fbap_in_if, fbap_out_if, fader_block_average_percent_unit
`timescale 1ns / 1ps

module tb_fader_block_average_percent_unit;

    // one frame word: sample of channel c in slot c
    typedef logic [fbap_pkg::MAX_CH-1:0][fbap_pkg::SAMPLE_W-1:0] t_frame;

    // one block result word as it leaves the block
    typedef struct packed {
        logic [fbap_pkg::MAX_CH-1:0][fbap_pkg::LEVEL_W-1:0]  level;
        logic [fbap_pkg::MAX_CH-1:0][fbap_pkg::SAMPLE_W-1:0] mean;
        logic [fbap_pkg::MAX_CH-1:0]                         changed_mask;
    } t_block_result;

    // running copy of the accumulator state plus the results still owed by the block
    class t_block_tracker;
        fbap_pkg::t_sum                                     acc [fbap_pkg::MAX_CH];
        int unsigned                                        frames_in_block;
        logic [fbap_pkg::MAX_CH-1:0][fbap_pkg::LEVEL_W-1:0] last_level;
        t_block_result                                      expected_blocks [$];
        int unsigned                                        error_count;

        function new();
            for (int c = 0; c < fbap_pkg::MAX_CH; c++) begin
                acc[c] = '0;
            end
            frames_in_block = 0;
            last_level      = '0;
            error_count     = 0;
        endfunction

        // add one accepted frame; a closing frame yields one expected result
        function void note_frame(t_frame f);
            t_block_result r;
            logic [fbap_pkg::SAMPLE_W-1:0] m;
            logic [fbap_pkg::LEVEL_W-1:0]  lv;
            for (int c = 0; c < fbap_pkg::MAX_CH; c++) begin
                if (c < fbap_pkg::CHANNELS) begin
                    acc[c] = acc[c] + fbap_pkg::t_sum'(f[c]);
                end
            end
            frames_in_block++;
            if (frames_in_block < fbap_pkg::BLOCK_LENGTH) begin
                return;
            end
            r = '0;
            for (int c = 0; c < fbap_pkg::MAX_CH; c++) begin
                m  = '0;
                lv = '0;
                if (c < fbap_pkg::CHANNELS) begin
                    m  = fbap_pkg::SAMPLE_W'(acc[c] / fbap_pkg::BLOCK_LENGTH);
                    lv = fbap_pkg::LEVEL_W'(m / fbap_pkg::LEVEL_DIVISOR);
                    if (lv != last_level[c]) begin
                        r.changed_mask[c] = 1'b1;
                        last_level[c]     = lv;
                    end
                end
                r.level[c] = lv;
                r.mean[c]  = m;
                acc[c]     = '0;
            end
            frames_in_block = 0;
            expected_blocks.push_back(r);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_block(t_block_result got);
            t_block_result want;
            if (expected_blocks.size() == 0) begin
                $error("result word with no prediction pending");
                error_count++;
                return;
            end
            want = expected_blocks.pop_front();
            for (int c = 0; c < fbap_pkg::MAX_CH; c++) begin
                if (got.level[c] !== want.level[c]) begin
                    $error("level_%0d expected %0d actual %0d", c, want.level[c], got.level[c]);
                    error_count++;
                end
                if (got.mean[c] !== want.mean[c]) begin
                    $error("mean_%0d expected %0d actual %0d", c, want.mean[c], got.mean[c]);
                    error_count++;
                end
            end
            if (got.changed_mask !== want.changed_mask) begin
                $error("changed_mask expected %0h actual %0h",
                       want.changed_mask, got.changed_mask);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fbap_in_if  frame_if ();
    fbap_out_if block_if ();

    fader_block_average_percent_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_if),
        .o_block (block_if)
    );

    // 12 ns period
    always #6 i_clk = ~i_clk;

    t_block_tracker tracker = new();

    // idle odds in percent, changed per phase
    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 62;

    // per-channel value a random block settles on; kept across blocks so levels can repeat
    t_frame held_base = '0;

    // receiver: check every accepted result word, then pick the next ready
    always @(posedge i_clk) begin
        t_block_result got;
        if (!i_rst_n) begin
            block_if.ready <= 1'b0;
        end else begin
            if (block_if.valid && block_if.ready) begin
                got.level        = {block_if.level_3, block_if.level_2,
                                    block_if.level_1, block_if.level_0};
                got.mean         = {block_if.mean_3, block_if.mean_2,
                                    block_if.mean_1, block_if.mean_0};
                got.changed_mask = block_if.changed_mask;
                tracker.check_block(got);
            end
            block_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // offer one frame word, with random idle cycles ahead of it, and hold until taken
    task automatic send_frame(t_frame f);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            frame_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        frame_if.valid    <= 1'b1;
        frame_if.sample_0 <= f[0];
        frame_if.sample_1 <= f[1];
        frame_if.sample_2 <= f[2];
        frame_if.sample_3 <= f[3];
        @(posedge i_clk);
        while (!frame_if.ready) begin
            @(posedge i_clk);
        end
        tracker.note_frame(f);
    endtask

    // stop sending until the block has handed over every owed result
    task automatic drain_results();
        frame_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // first block: extremes per channel, truncated mean, level boundary and
    // a channel whose mean truncates to zero so its change bit stays clear
    task automatic run_directed_block();
        t_frame f;
        for (int i = 0; i < fbap_pkg::BLOCK_LENGTH; i++) begin
            f[0] = 12'hfff;
            f[1] = (i == 0) ? 12'd15 : 12'd0;
            f[2] = (i % 2 == 0) ? 12'hfff : 12'h000;
            f[3] = 12'd41;
            send_frame(f);
        end
    endtask

    // random blocks: most hold a steady value per channel so means and levels are exact,
    // some repeat the last value so change bits clear, a quarter are pure noise
    task automatic run_random_blocks(int n_blocks);
        t_frame f;
        int     pick;
        bit     noisy;
        int     k;
        for (int b = 0; b < n_blocks; b++) begin
            for (int c = 0; c < fbap_pkg::MAX_CH; c++) begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0, 1: begin
                        // keep last value, level unchanged
                    end
                    2: begin
                        held_base[c] = fbap_pkg::SAMPLE_W'($urandom_range(0, 4095));
                    end
                    3: begin
                        // right at or just below a level step
                        k = $urandom_range(1, 99);
                        held_base[c] = fbap_pkg::SAMPLE_W'(41 * k - $urandom_range(0, 1));
                    end
                    4: begin
                        held_base[c] = 12'h000;
                    end
                    default: begin
                        held_base[c] = 12'hfff;
                    end
                endcase
            end
            noisy = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < fbap_pkg::BLOCK_LENGTH; i++) begin
                for (int c = 0; c < fbap_pkg::MAX_CH; c++) begin
                    f[c] = noisy ? fbap_pkg::SAMPLE_W'($urandom_range(0, 4095))
                                 : held_base[c];
                end
                send_frame(f);
            end
        end
    endtask

    initial begin
        t_frame f;
        frame_if.valid    <= 1'b0;
        frame_if.sample_0 <= '0;
        frame_if.sample_1 <= '0;
        frame_if.sample_2 <= '0;
        frame_if.sample_3 <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase one: sender idles lightly, receiver heavily
        run_directed_block();
        run_random_blocks(32);
        drain_results();

        // phase two: roles swapped
        send_idle_pct = 62;
        recv_idle_pct = 34;
        run_random_blocks(32);
        drain_results();

        // phase three: full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_blocks(33);

        // trailing partial block, never closes so never yields a result
        for (int i = 0; i < 5; i++) begin
            for (int c = 0; c < fbap_pkg::MAX_CH; c++) begin
                f[c] = fbap_pkg::SAMPLE_W'($urandom_range(0, 4095));
            end
            send_frame(f);
        end
        frame_if.valid <= 1'b0;

        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        // wait on to catch stray result words
        repeat (10) @(posedge i_clk);

        if (tracker.error_count == 0 && tracker.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/fbap_pkg.sv
rtl/fbap_in_if.sv
rtl/fbap_out_if.sv
rtl/fbap_front.sv
rtl/fbap_queue.sv
rtl/fbap_back.sv
rtl/fader_block_average_percent_unit.sv
rtl/fbap_checker.sv
tb/sv/tb_fader_block_average_percent_unit.sv
